// File: rtl/dqu_pkg.sv
// Shared constants, codes and types of the double-ended queue unit.
// Used by the channel interfaces, the cell, the controller and the top level.
// Depends on nothing.
package dqu_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_REAR  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_REAR   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_REAR  = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              shift_right;
    logic              shift_left;
    logic              write_rear;
    logic [DATA_W-1:0] wdata;
    logic [CNT_W-1:0]  count;
  } cell_cmd_t;

endpackage

// File: rtl/dqu_in_if.sv
// Operation channel of the double-ended queue unit: valid, ready and payload.
// Depends on dqu_pkg.
interface dqu_in_if;
  logic                      valid;
  logic                      ready;
  logic [dqu_pkg::OP_W-1:0]  operation;
  logic [dqu_pkg::DATA_W-1:0] data_in;

  modport source (output valid, output operation, output data_in, input ready);
  modport sink (input valid, input operation, input data_in, output ready);
endinterface

// File: rtl/dqu_out_if.sv
// Result channel of the double-ended queue unit: valid, ready and payload.
// Depends on dqu_pkg.
interface dqu_out_if;
  logic                       valid;
  logic                       ready;
  logic [dqu_pkg::DATA_W-1:0] data_out;
  logic [dqu_pkg::ST_W-1:0]   status;
  logic                       is_empty;
  logic [dqu_pkg::CNT_W-1:0]  entry_count;

  modport source (output valid, output data_out, output status, output is_empty,
                  output entry_count, input ready);
  modport sink (input valid, input data_out, input status, input is_empty,
                input entry_count, output ready);
endinterface

// File: rtl/dqu_cell.sv
// One storage cell of the queue row: holds one word, trades it with its
// neighbors on front pushes and pops, and takes a rear push at the free slot. Depends on dqu_pkg.
module dqu_cell (
  input  logic                       clk,
  input  logic [dqu_pkg::CNT_W-1:0]  idx,
  input  dqu_pkg::cell_cmd_t         cmd,
  input  logic [dqu_pkg::DATA_W-1:0] left_data,
  input  logic [dqu_pkg::DATA_W-1:0] right_data,
  output logic [dqu_pkg::DATA_W-1:0] data,
  output logic [dqu_pkg::DATA_W-1:0] rear_data
);

  logic [dqu_pkg::DATA_W-1:0] data_r;
  logic [dqu_pkg::DATA_W-1:0] data_nxt;
  logic                       is_rear;

  assign is_rear   = (cmd.count == idx + dqu_pkg::CNT_W'(1));
  assign data      = data_r;
  assign rear_data = is_rear ? data_r : '0;

  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_right) begin
      data_nxt = left_data;
    end else if (cmd.shift_left) begin
      data_nxt = right_data;
    end else if (cmd.write_rear && (cmd.count == idx)) begin
      data_nxt = cmd.wdata;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// File: rtl/dqu_ctrl.sv
// Controller of the queue: entry count, operation decode, cell commands and
// the registered result beat. Depends on dqu_pkg.
module dqu_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dqu_pkg::OP_W-1:0]   in_operation,
  input  logic [dqu_pkg::DATA_W-1:0] in_data_in,
  input  logic [dqu_pkg::DATA_W-1:0] front_data,
  input  logic [dqu_pkg::DATA_W-1:0] rear_data,
  output dqu_pkg::cell_cmd_t         cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [dqu_pkg::DATA_W-1:0] out_data_out,
  output logic [dqu_pkg::ST_W-1:0]   out_status,
  output logic                       out_is_empty,
  output logic [dqu_pkg::CNT_W-1:0]  out_entry_count
);

  logic                       fire;
  logic                       full;
  logic                       empty;
  logic [dqu_pkg::CNT_W-1:0]  count_r;
  logic [dqu_pkg::CNT_W-1:0]  count_nxt;
  logic                       out_valid_r;
  logic [dqu_pkg::DATA_W-1:0] data_out_r;
  logic [dqu_pkg::DATA_W-1:0] data_out_nxt;
  logic [dqu_pkg::ST_W-1:0]   status_r;
  logic [dqu_pkg::ST_W-1:0]   status_nxt;
  logic                       is_empty_r;
  logic [dqu_pkg::CNT_W-1:0]  entry_count_r;

  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign full     = (count_r == dqu_pkg::CNT_W'(dqu_pkg::DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    cmd.shift_right = 1'b0;
    cmd.shift_left  = 1'b0;
    cmd.write_rear  = 1'b0;
    cmd.wdata       = in_data_in;
    cmd.count       = count_r;
    count_nxt       = count_r;
    data_out_nxt    = '0;
    status_nxt      = dqu_pkg::ST_OK;
    case (in_operation)
      dqu_pkg::OP_PUSH_FRONT, dqu_pkg::OP_PUSH_REAR: begin
        if (full) begin
          status_nxt = dqu_pkg::ST_FULL;
        end else begin
          cmd.shift_right = fire && (in_operation == dqu_pkg::OP_PUSH_FRONT);
          cmd.write_rear  = fire && (in_operation == dqu_pkg::OP_PUSH_REAR);
          count_nxt       = count_r + dqu_pkg::CNT_W'(1);
        end
      end
      dqu_pkg::OP_POP_FRONT, dqu_pkg::OP_PEEK_FRONT: begin
        if (empty) begin
          status_nxt = dqu_pkg::ST_EMPTY;
        end else begin
          data_out_nxt = front_data;
          if (in_operation == dqu_pkg::OP_POP_FRONT) begin
            cmd.shift_left = fire;
            count_nxt      = count_r - dqu_pkg::CNT_W'(1);
          end
        end
      end
      dqu_pkg::OP_POP_REAR, dqu_pkg::OP_PEEK_REAR: begin
        if (empty) begin
          status_nxt = dqu_pkg::ST_EMPTY;
        end else begin
          data_out_nxt = rear_data;
          if (in_operation == dqu_pkg::OP_POP_REAR) begin
            count_nxt = count_r - dqu_pkg::CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        count_r <= count_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      data_out_r    <= data_out_nxt;
      status_r      <= status_nxt;
      is_empty_r    <= (count_nxt == '0);
      entry_count_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_out    = data_out_r;
  assign out_status      = status_r;
  assign out_is_empty    = is_empty_r;
  assign out_entry_count = entry_count_r;

endmodule

// File: rtl/double_ended_queue_unit.sv
// Channel    | Direction | Payload
// in_ch      | sink      | operation, data_in
// out_ch     | source    | data_out, status, is_empty, entry_count
//
// One operation is taken per cycle while no result stalls; its result beat
// appears in the next cycle from the output register, and the next operation
// is taken in that cycle whenever the result is consumed or the register is
// free. The row of cells keeps the front entry in the first cell: a front
// push or pop shifts the whole row by one position at once. Reset (rst_n,
// synchronous) clears the count and the result valid; cell contents are left
// as they are. A stalled result holds its beat and blocks new operations.
// Depends on dqu_pkg, dqu_in_if, dqu_out_if, dqu_cell and dqu_ctrl.
module double_ended_queue_unit (
  input logic      clk,
  input logic      rst_n,
  dqu_in_if.sink   in_ch,
  dqu_out_if.source out_ch
);

  dqu_pkg::cell_cmd_t         cmd;
  logic [dqu_pkg::DATA_W-1:0] cell_q [dqu_pkg::DEPTH];
  logic [dqu_pkg::DATA_W-1:0] cell_rear [dqu_pkg::DEPTH];
  logic [dqu_pkg::DATA_W-1:0] rear_data;

  for (genvar i = 0; i < dqu_pkg::DEPTH; i++) begin : g_cell
    logic [dqu_pkg::DATA_W-1:0] left_data;
    logic [dqu_pkg::DATA_W-1:0] right_data;

    if (i == 0) begin : g_first
      assign left_data = cmd.wdata;
    end else begin : g_mid_left
      assign left_data = cell_q[i-1];
    end

    if (i == dqu_pkg::DEPTH - 1) begin : g_last
      assign right_data = cell_q[i];
    end else begin : g_mid_right
      assign right_data = cell_q[i+1];
    end

    dqu_cell u_cell (
      .clk        (clk),
      .idx        (dqu_pkg::CNT_W'(i)),
      .cmd        (cmd),
      .left_data  (left_data),
      .right_data (right_data),
      .data       (cell_q[i]),
      .rear_data  (cell_rear[i])
    );
  end

  always_comb begin
    rear_data = '0;
    for (int i = 0; i < dqu_pkg::DEPTH; i++) begin
      rear_data = rear_data | cell_rear[i];
    end
  end

  dqu_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_operation    (in_ch.operation),
    .in_data_in      (in_ch.data_in),
    .front_data      (cell_q[0]),
    .rear_data       (rear_data),
    .cmd             (cmd),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_data_out    (out_ch.data_out),
    .out_status      (out_ch.status),
    .out_is_empty    (out_ch.is_empty),
    .out_entry_count (out_ch.entry_count)
  );

`ifndef SYNTH
  a_fire_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> out_ch.valid)
    else $error("accepted operation produced no result beat");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.entry_count <= dqu_pkg::CNT_W'(dqu_pkg::DEPTH)))
    else $error("entry count above capacity");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.is_empty == (out_ch.entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.status != dqu_pkg::ST_OK)) |-> (out_ch.data_out == '0))
    else $error("error beat carries nonzero data");
`endif

endmodule

// File: test/tb_double_ended_queue_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue_unit: directed and random beats of push,
// pop and peek at both ends plus undefined codes, checked against a ring-buffer prediction.
// Depends on dqu_pkg, dqu_in_if, dqu_out_if and the unit itself.
module tb_double_ended_queue_unit;

  localparam int IDX_W = $clog2(dqu_pkg::DEPTH);
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_OPS = 1200;
  localparam logic [dqu_pkg::OP_W-1:0] OP_UNDEF_LO = 3'd6;
  localparam logic [dqu_pkg::OP_W-1:0] OP_UNDEF_HI = 3'd7;

  typedef enum int {MIX_FILL, MIX_BALANCED, MIX_DRAIN, MIX_PEEK} mix_t;

  typedef struct packed {
    logic [dqu_pkg::OP_W-1:0]   code;
    logic [dqu_pkg::DATA_W-1:0] word;
  } deque_op_t;

  typedef struct packed {
    logic [dqu_pkg::DATA_W-1:0] data;
    dqu_pkg::status_t           status;
    logic                       is_empty;
    logic [dqu_pkg::CNT_W-1:0]  count;
  } deque_result_t;

  logic clk = 1'b0;
  logic rst_n;

  dqu_in_if  in_ch();
  dqu_out_if out_ch();

  double_ended_queue_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [dqu_pkg::DATA_W-1:0] dq_words [dqu_pkg::DEPTH];
  logic [IDX_W-1:0]           dq_head = '0;
  logic [dqu_pkg::CNT_W-1:0]  dq_count = '0;

  deque_op_t     stimulus_items [$];
  deque_result_t predicted_results [$];
  deque_op_t     next_op;
  deque_result_t want_result;
  deque_result_t seen_result;

  int cycle_count = 0;
  int ops_accepted = 0;
  int results_checked = 0;
  int error_count = 0;
  int full_rejects = 0;
  int empty_errors = 0;
  int undefined_ops = 0;
  int peak_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic quiet_phase;

  // Every fourth stretch of the cycle count draws no new idle gaps on either side.
  assign quiet_phase = ((cycle_count / 3000) % 4) == 3;

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [dqu_pkg::OP_W-1:0] pick_code(int lo, int hi);
    return dqu_pkg::OP_W'($urandom_range(hi, lo));
  endfunction

  function automatic deque_result_t deque_apply(logic [dqu_pkg::OP_W-1:0] code,
                                                logic [dqu_pkg::DATA_W-1:0] word);
    deque_result_t r;
    logic [IDX_W-1:0] idx;
    r.data = '0;
    r.status = dqu_pkg::ST_OK;
    case (code)
      dqu_pkg::OP_PUSH_FRONT, dqu_pkg::OP_PUSH_REAR: begin
        if (dq_count == dqu_pkg::CNT_W'(dqu_pkg::DEPTH)) begin
          r.status = dqu_pkg::ST_FULL;
          full_rejects++;
        end else begin
          if (code == dqu_pkg::OP_PUSH_FRONT) begin
            dq_head = dq_head - IDX_W'(1);
            dq_words[dq_head] = word;
          end else begin
            idx = dq_head + IDX_W'(dq_count);
            dq_words[idx] = word;
          end
          dq_count = dq_count + dqu_pkg::CNT_W'(1);
        end
      end
      dqu_pkg::OP_POP_FRONT, dqu_pkg::OP_PEEK_FRONT,
      dqu_pkg::OP_POP_REAR, dqu_pkg::OP_PEEK_REAR: begin
        if (dq_count == '0) begin
          r.status = dqu_pkg::ST_EMPTY;
          empty_errors++;
        end else if (code == dqu_pkg::OP_POP_FRONT || code == dqu_pkg::OP_PEEK_FRONT) begin
          r.data = dq_words[dq_head];
          if (code == dqu_pkg::OP_POP_FRONT) begin
            dq_head = dq_head + IDX_W'(1);
            dq_count = dq_count - dqu_pkg::CNT_W'(1);
          end
        end else begin
          idx = dq_head + IDX_W'(dq_count - dqu_pkg::CNT_W'(1));
          r.data = dq_words[idx];
          if (code == dqu_pkg::OP_POP_REAR) dq_count = dq_count - dqu_pkg::CNT_W'(1);
        end
      end
      default: begin
        undefined_ops++;
      end
    endcase
    r.is_empty = (dq_count == '0);
    r.count = dq_count;
    if (int'(dq_count) > peak_count) peak_count = int'(dq_count);
    return r;
  endfunction

  task automatic log_failure(input string what);
    error_count++;
    if (error_count <= 10) $display("%s", what);
  endtask

  task automatic queue_op(input logic [dqu_pkg::OP_W-1:0] code,
                          input logic [dqu_pkg::DATA_W-1:0] word);
    stimulus_items.push_back('{code: code, word: word});
  endtask

  // Operation driver and input-side prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predicted_results.push_back(deque_apply(in_ch.operation, in_ch.data_in));
        ops_accepted <= ops_accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (send_gap != 0) begin
          in_ch.valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (stimulus_items.size() != 0) begin
          next_op = stimulus_items.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.operation <= next_op.code;
          in_ch.data_in <= next_op.word;
          if (!quiet_phase && $urandom_range(0, 99) < 30) send_gap <= draw_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver with random stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ch.ready <= 1'b1;
      if (!quiet_phase && $urandom_range(0, 99) < 25) stall_left <= draw_gap();
    end
  end

  // One long receiver hold-off while the sender keeps offering operations.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && ops_accepted >= 600) begin
      hold_left <= 250;
      hold_done <= 1'b1;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen_result.data = out_ch.data_out;
      seen_result.status = dqu_pkg::status_t'(out_ch.status);
      seen_result.is_empty = out_ch.is_empty;
      seen_result.count = out_ch.entry_count;
      if (predicted_results.size() == 0) begin
        log_failure($sformatf("unexpected result beat: data %h status %0d empty %0b count %0d",
                              seen_result.data, seen_result.status, seen_result.is_empty,
                              seen_result.count));
      end else begin
        want_result = predicted_results.pop_front();
        results_checked <= results_checked + 1;
        if (seen_result.data !== want_result.data || seen_result.status !== want_result.status ||
            seen_result.is_empty !== want_result.is_empty ||
            seen_result.count !== want_result.count) begin
          log_failure($sformatf({"mismatch: expected data %h status %0d empty %0b count %0d,",
                                 " got data %h status %0d empty %0b count %0d"},
                                want_result.data, want_result.status, want_result.is_empty,
                                want_result.count, seen_result.data, seen_result.status,
                                seen_result.is_empty, seen_result.count));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("double_ended_queue_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int generated;
    int phase;
    int span;
    int r;
    mix_t mix;
    logic [dqu_pkg::OP_W-1:0] code;
    logic [dqu_pkg::DATA_W-1:0] word;

    rst_n = 1'b0;

    // Errors on an empty queue, undefined codes, data extremes, head wrap on a front push.
    queue_op(dqu_pkg::OP_PEEK_FRONT, '1);
    queue_op(dqu_pkg::OP_PEEK_REAR, '0);
    queue_op(dqu_pkg::OP_POP_FRONT, '1);
    queue_op(dqu_pkg::OP_POP_REAR, '0);
    queue_op(OP_UNDEF_LO, '1);
    queue_op(OP_UNDEF_HI, '1);
    queue_op(dqu_pkg::OP_PUSH_FRONT, '1);
    queue_op(dqu_pkg::OP_PUSH_REAR, '0);
    queue_op(dqu_pkg::OP_PUSH_FRONT, 32'h5A5A_A5A5);
    queue_op(dqu_pkg::OP_PUSH_REAR, 32'h8000_0001);
    queue_op(dqu_pkg::OP_PEEK_FRONT, '0);
    queue_op(dqu_pkg::OP_PEEK_REAR, '1);
    queue_op(OP_UNDEF_HI, 32'h1234_5678);
    queue_op(dqu_pkg::OP_POP_REAR, '0);
    queue_op(dqu_pkg::OP_POP_FRONT, '0);
    queue_op(dqu_pkg::OP_POP_FRONT, '0);
    queue_op(dqu_pkg::OP_PEEK_REAR, '0);
    queue_op(dqu_pkg::OP_POP_REAR, '0);
    queue_op(dqu_pkg::OP_POP_FRONT, '0);
    queue_op(dqu_pkg::OP_PEEK_FRONT, '0);

    generated = 0;
    phase = 0;
    while (generated < RANDOM_OPS) begin
      mix = mix_t'(phase % 4);
      span = (mix == MIX_FILL) ? $urandom_range(80, 110) : $urandom_range(30, 90);
      repeat (span) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          code = pick_code(OP_UNDEF_LO, OP_UNDEF_HI);
        end else begin
          r = $urandom_range(0, 99);
          case (mix)
            MIX_FILL: code = (r < 90)
                ? pick_code(dqu_pkg::OP_PUSH_FRONT, dqu_pkg::OP_PUSH_REAR)
                : pick_code(dqu_pkg::OP_POP_FRONT, dqu_pkg::OP_PEEK_REAR);
            MIX_DRAIN: code = (r < 85)
                ? pick_code(dqu_pkg::OP_POP_FRONT, dqu_pkg::OP_POP_REAR)
                : pick_code(dqu_pkg::OP_PUSH_FRONT, dqu_pkg::OP_PEEK_REAR);
            MIX_PEEK: code = (r < 50)
                ? pick_code(dqu_pkg::OP_PEEK_FRONT, dqu_pkg::OP_PEEK_REAR)
                : pick_code(dqu_pkg::OP_PUSH_FRONT, dqu_pkg::OP_PEEK_REAR);
            default: code = pick_code(dqu_pkg::OP_PUSH_FRONT, dqu_pkg::OP_PEEK_REAR);
          endcase
        end
        r = $urandom_range(0, 99);
        if (r < 10) word = '0;
        else if (r < 20) word = '1;
        else word = $urandom;
        queue_op(code, word);
        generated++;
      end
      phase++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (stimulus_items.size() != 0 || in_ch.valid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    $display("checked %0d result beats from %0d operations; peak occupancy %0d of %0d",
             results_checked, ops_accepted, peak_count, dqu_pkg::DEPTH);
    $display("pushes refused when full %0d, pops and peeks on empty %0d, undefined codes %0d",
             full_rejects, empty_errors, undefined_ops);
    if (error_count == 0) begin
      $display("double_ended_queue_unit regression: pass");
    end else begin
      $display("double_ended_queue_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/dqu_pkg.sv
rtl/dqu_in_if.sv
rtl/dqu_out_if.sv
rtl/dqu_cell.sv
rtl/dqu_ctrl.sv
rtl/double_ended_queue_unit.sv
test/tb_double_ended_queue_unit.sv
